FILE: rtl/csfd_pkg.sv
// Shared types, frame identifiers, read indexes and helper functions for the
// CAN signal frame decoder. No dependencies; every other source file depends on this.
package csfd_pkg;

  localparam int EVENT_DEPTH_DEF = 8;

  localparam int ID_W    = 29;
  localparam int LEN_W   = 4;
  localparam int PL_W    = 64;
  localparam int IDX_W   = 6;
  localparam int VAL_W   = 25;
  localparam int CODE_W  = 4;
  localparam int ENTRY_W = CODE_W + 1;
  localparam int DIST_W  = 7;
  localparam int ZONES   = 8;

  typedef enum logic [1:0] {
    REQ_FRAME   = 2'd0,
    REQ_READ    = 2'd1,
    REQ_DEQUEUE = 2'd2,
    REQ_UNUSED  = 2'd3
  } req_t;

  localparam logic [ID_W-1:0] ID_STEER   = ID_W'(32'h080);
  localparam logic [ID_W-1:0] ID_ODO     = ID_W'(32'h072);
  localparam logic [ID_W-1:0] ID_BUTTON  = ID_W'(32'h1A9);
  localparam logic [ID_W-1:0] ID_SPEED   = ID_W'(32'h217);
  localparam logic [ID_W-1:0] ID_BATT    = ID_W'(32'h230);
  localparam logic [ID_W-1:0] ID_GEAR    = ID_W'(32'h165);
  localparam logic [ID_W-1:0] ID_CLIMATE = ID_W'(32'h3B5);
  localparam logic [ID_W-1:0] ID_COOLANT = ID_W'(32'h420);
  localparam logic [ID_W-1:0] ID_LIGHTS  = ID_W'(32'h4B0);
  localparam logic [ID_W-1:0] ID_BODY    = ID_W'(32'h540);
  localparam logic [ID_W-1:0] ID_PARK    = ID_W'(32'h5C0);

  localparam int ZONE_STEP = 14;
  localparam logic [DIST_W-1:0] DIST_CLEAR = DIST_W'(99);
  localparam logic [7:0] COOLANT_OFS = 8'd40;
  localparam logic [7:0] COOLANT_TOP = 8'd167;
  localparam logic [7:0] COOLANT_MAX = 8'd127;
  localparam logic [6:0] VOLT_SCALE  = 7'd100;

  // Read index map
  localparam logic [IDX_W-1:0] SIG_SPEED      = 6'd0;
  localparam logic [IDX_W-1:0] SIG_RPM        = 6'd1;
  localparam logic [IDX_W-1:0] SIG_COOLANT    = 6'd2;
  localparam logic [IDX_W-1:0] SIG_VOLTAGE    = 6'd3;
  localparam logic [IDX_W-1:0] SIG_ODOMETER   = 6'd4;
  localparam logic [IDX_W-1:0] SIG_GEAR       = 6'd5;
  localparam logic [IDX_W-1:0] SIG_PARK_BRAKE = 6'd6;
  localparam logic [IDX_W-1:0] SIG_DOOR_FL    = 6'd7;
  localparam logic [IDX_W-1:0] SIG_DOOR_FR    = 6'd8;
  localparam logic [IDX_W-1:0] SIG_DOOR_RL    = 6'd9;
  localparam logic [IDX_W-1:0] SIG_DOOR_RR    = 6'd10;
  localparam logic [IDX_W-1:0] SIG_TAILGATE   = 6'd11;
  localparam logic [IDX_W-1:0] SIG_BONNET     = 6'd12;
  localparam logic [IDX_W-1:0] SIG_NEAR_LIGHT = 6'd13;
  localparam logic [IDX_W-1:0] SIG_AC         = 6'd14;
  localparam logic [IDX_W-1:0] SIG_FAN        = 6'd15;
  localparam logic [IDX_W-1:0] SIG_SET_DRV    = 6'd16;
  localparam logic [IDX_W-1:0] SIG_SET_PAS    = 6'd17;
  localparam logic [IDX_W-1:0] SIG_RECIRC     = 6'd18;
  localparam logic [IDX_W-1:0] SIG_VENT_WS    = 6'd19;
  localparam logic [IDX_W-1:0] SIG_VENT_MID   = 6'd20;
  localparam logic [IDX_W-1:0] SIG_VENT_FLOOR = 6'd21;
  localparam logic [IDX_W-1:0] SIG_DUAL_ZONE  = 6'd22;
  localparam logic [IDX_W-1:0] SIG_STEERING   = 6'd23;
  localparam logic [IDX_W-1:0] SIG_PARK_ON    = 6'd24;
  localparam logic [IDX_W-1:0] SIG_PARK_D0    = 6'd25;
  localparam logic [IDX_W-1:0] SIG_PARK_D7    = 6'd32;

  typedef struct packed {
    logic            we;
    logic [ID_W-1:0] can_id;
    logic [LEN_W-1:0] len;
    logic [PL_W-1:0] payload;
  } frame_t;

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
    logic              pressed;
  } push_t;

  // Zone to distance: clear for zone 0, otherwise (6 - min(z,6)) steps
  function automatic logic [DIST_W-1:0] zone_dist(input logic [7:0] z);
    logic [DIST_W-1:0] d;
    if (z == 8'd0) begin
      d = DIST_CLEAR;
    end else if (z >= 8'd6) begin
      d = '0;
    end else begin
      d = DIST_W'((3'd6 - z[2:0]) * ZONE_STEP);
    end
    return d;
  endfunction

  // One-hot bit position plus one, zero for anything not one-hot
  function automatic logic [CODE_W-1:0] button_code(input logic [7:0] b);
    logic [CODE_W-1:0] c;
    c = '0;
    for (int k = 0; k < 8; k++) begin
      if (b == 8'(1 << k)) c = CODE_W'(k + 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/csfd_if.sv
// Valid/ready channel interfaces for the request and result beats.
// Depends on csfd_pkg for field widths.
interface csfd_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_type;
  logic [csfd_pkg::ID_W-1:0]     can_id;
  logic [csfd_pkg::LEN_W-1:0]    frame_length;
  logic [csfd_pkg::PL_W-1:0]     payload;
  logic [csfd_pkg::IDX_W-1:0]    signal_index;

  modport source (output valid, req_type, can_id, frame_length, payload, signal_index,
                  input ready);
  modport sink   (input valid, req_type, can_id, frame_length, payload, signal_index,
                  output ready);
endinterface

interface csfd_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [csfd_pkg::VAL_W-1:0] read_value;
  logic                              event_valid;
  logic [csfd_pkg::CODE_W-1:0]       button_code;
  logic                              button_pressed;

  modport source (output valid, read_value, event_valid, button_code, button_pressed,
                  input ready);
  modport sink   (input valid, read_value, event_valid, button_code, button_pressed,
                  output ready);
endinterface

FILE: rtl/can_signal_frame_decoder_top.sv
// CAN signal frame decoder, top level. A read or dequeue result beat
// is registered through two stages, stage one and the output register,
// before it is offered. Frames take effect on the cycle after acceptance.
// Throughput: one request per cycle while results are taken; a stalled
// result holds the input once both result stages are full. Reset (rst_n
// low, synchronous) clears all signals, pointers and the fill count and
// holds the input off; the event memory is not cleared and needs no sweep.
module can_signal_frame_decoder_top #(
  parameter int EVENT_DEPTH = csfd_pkg::EVENT_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  csfd_in_if.sink    in_bus,
  csfd_out_if.source out_bus
);
  import csfd_pkg::*;

  logic accept;
  logic s1_adv;
  logic is_frame, is_read, is_deq;

  logic               s1_valid_r, s1_valid_nxt;
  logic               s1_deq_r;
  logic [VAL_W-1:0]   s1_value_r;

  logic               out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]   out_value_r;
  logic               out_ev_r;
  logic [CODE_W-1:0]  out_code_r;
  logic               out_pr_r;

  frame_t             frame;
  push_t              push;
  logic [7:0]         btn_b0;
  logic [CODE_W-1:0]  btn_code;
  logic signed [VAL_W-1:0] sig_value;
  logic               ev_hit;
  logic [ENTRY_W-1:0] ev_entry;

  assign s1_adv       = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = rst_n && (!s1_valid_r || s1_adv);
  assign accept       = in_bus.valid && in_bus.ready;

  assign is_frame = (in_bus.req_type == REQ_FRAME);
  assign is_read  = (in_bus.req_type == REQ_READ);
  assign is_deq   = (in_bus.req_type == REQ_DEQUEUE);

  assign frame.we      = accept && is_frame;
  assign frame.can_id  = in_bus.can_id;
  assign frame.len     = in_bus.frame_length;
  assign frame.payload = in_bus.payload;

  assign btn_b0       = in_bus.payload[7:0];
  assign btn_code     = button_code(btn_b0);
  assign push.valid   = frame.we && (in_bus.can_id == ID_BUTTON) &&
                        (in_bus.frame_length >= LEN_W'(2)) && (btn_code != '0);
  assign push.code    = btn_code;
  assign push.pressed = in_bus.payload[8];

  csfd_sig_bank u_sig_bank (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame        (frame),
    .signal_index (in_bus.signal_index),
    .read_value   (sig_value)
  );

  csfd_evq #(
    .EVENT_DEPTH (EVENT_DEPTH)
  ) u_evq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .pop     (accept && is_deq),
    .hit_r   (ev_hit),
    .entry_r (ev_entry)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = is_read || is_deq;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Stage one holds the read value; dequeue data comes from the memory port
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_deq_r   <= is_deq;
      s1_value_r <= is_read ? sig_value : '0;
    end
    if (s1_adv) begin
      out_value_r <= s1_value_r;
      out_ev_r    <= s1_deq_r && ev_hit;
      out_code_r  <= (s1_deq_r && ev_hit) ? ev_entry[CODE_W-1:0] : '0;
      out_pr_r    <= (s1_deq_r && ev_hit) ? ev_entry[CODE_W] : 1'b0;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.read_value     = out_value_r;
  assign out_bus.event_valid    = out_ev_r;
  assign out_bus.button_code    = out_code_r;
  assign out_bus.button_pressed = out_pr_r;

endmodule

FILE: rtl/csfd_sig_bank.sv
// Decoded signal registers: frame decode, register update and read mux.
// Depends on csfd_pkg.
module csfd_sig_bank (
  input  logic                              clk,
  input  logic                              rst_n,
  input  csfd_pkg::frame_t                  frame,
  input  logic [csfd_pkg::IDX_W-1:0]        signal_index,
  output logic signed [csfd_pkg::VAL_W-1:0] read_value
);
  import csfd_pkg::*;

  logic [15:0] speed_r, speed_nxt;
  logic [13:0] rpm_r, rpm_nxt;
  logic [7:0]  coolant_r, coolant_nxt;
  logic [15:0] voltage_r, voltage_nxt;
  logic [23:0] odometer_r, odometer_nxt;
  logic [1:0]  gear_r, gear_nxt;
  logic [7:0]  body_r, body_nxt;
  logic [5:0]  climate_r, climate_nxt;
  logic [2:0]  fan_r, fan_nxt;
  logic [7:0]  set_drv_r, set_drv_nxt;
  logic [7:0]  set_pas_r, set_pas_nxt;
  logic [15:0] steer_r, steer_nxt;
  logic        park_on_r, park_on_nxt;
  logic [DIST_W-1:0] dist_r   [ZONES];
  logic [DIST_W-1:0] dist_nxt [ZONES];

  logic [7:0]       b [ZONES];
  logic [LEN_W-1:0] len_eff;
  logic [22:0]      volt_prod;

  always_comb begin
    for (int i = 0; i < ZONES; i++) b[i] = frame.payload[8*i +: 8];
    len_eff   = (frame.len > LEN_W'(8)) ? LEN_W'(8) : frame.len;
    volt_prod = {b[0], b[1]} * VOLT_SCALE;
  end

  always_comb begin
    speed_nxt    = speed_r;
    rpm_nxt      = rpm_r;
    coolant_nxt  = coolant_r;
    voltage_nxt  = voltage_r;
    odometer_nxt = odometer_r;
    gear_nxt     = gear_r;
    body_nxt     = body_r;
    climate_nxt  = climate_r;
    fan_nxt      = fan_r;
    set_drv_nxt  = set_drv_r;
    set_pas_nxt  = set_pas_r;
    steer_nxt    = steer_r;
    park_on_nxt  = park_on_r;
    for (int i = 0; i < ZONES; i++) dist_nxt[i] = dist_r[i];

    if (frame.we) begin
      case (frame.can_id)
        ID_SPEED: begin
          if (len_eff >= LEN_W'(4)) begin
            speed_nxt = {b[0], b[1]};
            rpm_nxt   = {b[2], b[3][7:2]};
          end
        end
        ID_COOLANT: begin
          if (len_eff >= LEN_W'(1)) begin
            coolant_nxt = (b[0] >= COOLANT_TOP) ? COOLANT_MAX : b[0] - COOLANT_OFS;
          end
        end
        ID_BATT: begin
          if (len_eff >= LEN_W'(2)) voltage_nxt = volt_prod[15:0];
        end
        ID_ODO: begin
          if (len_eff >= LEN_W'(4)) odometer_nxt = {b[1], b[2], b[3]};
        end
        ID_BODY: begin
          if (len_eff >= LEN_W'(1)) body_nxt = {body_r[7], b[0][6:0]};
        end
        ID_LIGHTS: begin
          if (len_eff >= LEN_W'(1)) body_nxt = {b[0][0], body_r[6:0]};
        end
        ID_GEAR: begin
          if (len_eff >= LEN_W'(1)) gear_nxt = (b[0][7:2] == 6'd0) ? b[0][1:0] : 2'd0;
        end
        ID_CLIMATE: begin
          if (len_eff >= LEN_W'(4)) begin
            climate_nxt[2:0] = b[0][2:0];
            fan_nxt          = b[1][3:1];
            set_drv_nxt      = b[2];
            set_pas_nxt      = b[3];
            if (len_eff >= LEN_W'(5)) climate_nxt[5:3] = b[4][2:0];
          end
        end
        ID_STEER: begin
          if (len_eff >= LEN_W'(2)) steer_nxt = {b[0], b[1]};
        end
        ID_PARK: begin
          if (len_eff >= LEN_W'(1)) begin
            park_on_nxt = b[0][0];
            // the last zone would need a ninth byte: always clear
            for (int i = 0; i < ZONES - 1; i++) begin
              dist_nxt[i] = (LEN_W'(i + 1) < len_eff) ? zone_dist(b[i+1]) : DIST_CLEAR;
            end
            dist_nxt[ZONES-1] = DIST_CLEAR;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r    <= '0;
      rpm_r      <= '0;
      coolant_r  <= '0;
      voltage_r  <= '0;
      odometer_r <= '0;
      gear_r     <= '0;
      body_r     <= '0;
      climate_r  <= '0;
      fan_r      <= '0;
      set_drv_r  <= '0;
      set_pas_r  <= '0;
      steer_r    <= '0;
      park_on_r  <= 1'b0;
      for (int i = 0; i < ZONES; i++) dist_r[i] <= '0;
    end else begin
      speed_r    <= speed_nxt;
      rpm_r      <= rpm_nxt;
      coolant_r  <= coolant_nxt;
      voltage_r  <= voltage_nxt;
      odometer_r <= odometer_nxt;
      gear_r     <= gear_nxt;
      body_r     <= body_nxt;
      climate_r  <= climate_nxt;
      fan_r      <= fan_nxt;
      set_drv_r  <= set_drv_nxt;
      set_pas_r  <= set_pas_nxt;
      steer_r    <= steer_nxt;
      park_on_r  <= park_on_nxt;
      for (int i = 0; i < ZONES; i++) dist_r[i] <= dist_nxt[i];
    end
  end

  logic [IDX_W-1:0] dist_off;

  always_comb begin
    dist_off   = signal_index - SIG_PARK_D0;
    read_value = '0;
    case (signal_index)
      SIG_SPEED:      read_value = VAL_W'(speed_r);
      SIG_RPM:        read_value = VAL_W'(rpm_r);
      SIG_COOLANT:    read_value = {{(VAL_W-8){coolant_r[7]}}, coolant_r};
      SIG_VOLTAGE:    read_value = VAL_W'(voltage_r);
      SIG_ODOMETER:   read_value = VAL_W'(odometer_r);
      SIG_GEAR:       read_value = VAL_W'(gear_r);
      SIG_PARK_BRAKE: read_value = VAL_W'(body_r[6]);
      SIG_DOOR_FL:    read_value = VAL_W'(body_r[0]);
      SIG_DOOR_FR:    read_value = VAL_W'(body_r[1]);
      SIG_DOOR_RL:    read_value = VAL_W'(body_r[2]);
      SIG_DOOR_RR:    read_value = VAL_W'(body_r[3]);
      SIG_TAILGATE:   read_value = VAL_W'(body_r[4]);
      SIG_BONNET:     read_value = VAL_W'(body_r[5]);
      SIG_NEAR_LIGHT: read_value = VAL_W'(body_r[7]);
      SIG_AC:         read_value = VAL_W'(climate_r[0]);
      SIG_FAN:        read_value = VAL_W'(fan_r);
      SIG_SET_DRV:    read_value = VAL_W'(set_drv_r);
      SIG_SET_PAS:    read_value = VAL_W'(set_pas_r);
      SIG_RECIRC:     read_value = VAL_W'(climate_r[1]);
      SIG_VENT_WS:    read_value = VAL_W'(climate_r[3]);
      SIG_VENT_MID:   read_value = VAL_W'(climate_r[4]);
      SIG_VENT_FLOOR: read_value = VAL_W'(climate_r[5]);
      SIG_DUAL_ZONE:  read_value = VAL_W'(climate_r[2]);
      SIG_STEERING:   read_value = {{(VAL_W-16){steer_r[15]}}, steer_r};
      SIG_PARK_ON:    read_value = VAL_W'(park_on_r);
      default: begin
        if (signal_index >= SIG_PARK_D0 && signal_index <= SIG_PARK_D7) begin
          read_value = VAL_W'(dist_r[dist_off[2:0]]);
        end
      end
    endcase
  end

endmodule

FILE: rtl/csfd_evq.sv
// Button event queue: synchronous event memory with registered read data,
// drop-oldest pointers and fill count. Depends on csfd_pkg.
module csfd_evq #(
  parameter int EVENT_DEPTH = csfd_pkg::EVENT_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  csfd_pkg::push_t                push,
  input  logic                           pop,
  output logic                           hit_r,
  output logic [csfd_pkg::ENTRY_W-1:0]   entry_r
);
  import csfd_pkg::*;

  localparam int PW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
  localparam int CW = $clog2(EVENT_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(EVENT_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(EVENT_DEPTH);

  logic [ENTRY_W-1:0] mem [EVENT_DEPTH];

  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          empty;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PW'(1);
  endfunction

  assign empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push.valid) begin
      wr_ptr_nxt = ptr_inc(wr_ptr_r);
      // full: drop the oldest beat, count stays
      if (count_r == CNT_FULL) begin
        rd_ptr_nxt = ptr_inc(rd_ptr_r);
      end else begin
        count_nxt = count_r + CW'(1);
      end
    end else if (pop && !empty) begin
      rd_ptr_nxt = ptr_inc(rd_ptr_r);
      count_nxt  = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      hit_r    <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      if (pop) hit_r <= !empty;
    end
  end

  // Push and pop never share a cycle, so no forwarding is needed
  always_ff @(posedge clk) begin
    if (push.valid) mem[wr_ptr_r] <= {push.pressed, push.code};
    if (pop) entry_r <= mem[rd_ptr_r];
  end

endmodule

FILE: rtl/csfd_chk.sv
// Port-level checks on the decoder's result channel, bound to the top level.
// Depends on csfd_pkg for field widths.
module csfd_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [csfd_pkg::VAL_W-1:0] read_value,
  input logic                              event_valid,
  input logic [csfd_pkg::CODE_W-1:0]       button_code,
  input logic                              button_pressed
);
  import csfd_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn while stalled");

  a_hold_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(button_code) && $stable(read_value))
    else $error("result beat changed while stalled");

  a_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !event_valid |-> button_code == '0 && !button_pressed)
    else $error("event fields set without an event");

  a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_valid |-> button_code != '0 && button_code <= CODE_W'(8))
    else $error("popped event carries an invalid button code");

  a_event_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_valid |-> read_value == '0)
    else $error("dequeue beat carries a read value");

endmodule

bind can_signal_frame_decoder_top csfd_chk u_csfd_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_bus.valid),
  .out_ready      (out_bus.ready),
  .read_value     (out_bus.read_value),
  .event_valid    (out_bus.event_valid),
  .button_code    (out_bus.button_code),
  .button_pressed (out_bus.button_pressed)
);

FILE: bench/tb_can_signal_frame_decoder_top.sv
`timescale 1ns / 100ps
// Self-checking bench for can_signal_frame_decoder_top: drives frames, reads and
// dequeues, mirrors the signal registers and event queue, and checks each result beat.
// Depends on csfd_pkg and the csfd_in_if / csfd_out_if channel interfaces.
module tb_can_signal_frame_decoder_top;
  import csfd_pkg::*;

  localparam int          QUEUE_DEPTH     = EVENT_DEPTH_DEF;
  localparam int unsigned ITEM_TARGET     = 1550;
  localparam int unsigned HOLD_OFF_CYCLES = 200;
  localparam int unsigned DRAIN_LIMIT     = 20000;

  localparam logic [ID_W-1:0] KNOWN_IDS [11] = '{
    ID_STEER, ID_ODO, ID_BUTTON, ID_SPEED, ID_BATT, ID_GEAR,
    ID_CLIMATE, ID_COOLANT, ID_LIGHTS, ID_BODY, ID_PARK
  };

  typedef struct {
    req_t              kind;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [PL_W-1:0]   data;
    logic [IDX_W-1:0]  idx;
  } request_t;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic              popped;
    logic [CODE_W-1:0] code;
    logic              pressed;
  } reply_t;

  typedef enum {RX_EAGER, RX_MOSTLY, RX_SPARSE, RX_PATTERN} rx_mode_t;

  // Mirror of the decoded signals and button queue, plus the results still owed
  class decoder_mirror;
    logic [15:0]       speed;
    logic [13:0]       rpm;
    logic [7:0]        coolant;
    logic [15:0]       volts;
    logic [23:0]       odometer;
    logic [1:0]        gear;
    logic [7:0]        body;
    logic [5:0]        climate;
    logic [2:0]        fan;
    logic [7:0]        setpoint [2];
    logic [15:0]       steer;
    logic              park_on;
    logic [DIST_W-1:0] park_dist [ZONES];
    logic [4:0]        events [$];
    reply_t            replies_due [$];
    int unsigned       mismatches;

    function new();
      speed = '0; rpm = '0; coolant = '0; volts = '0; odometer = '0; gear = '0;
      body = '0; climate = '0; fan = '0; steer = '0; park_on = 1'b0;
      setpoint[0] = '0; setpoint[1] = '0;
      foreach (park_dist[i]) park_dist[i] = '0;
      mismatches = 0;
    endfunction

    function bit recognises(logic [ID_W-1:0] id);
      case (id)
        ID_STEER, ID_ODO, ID_BUTTON, ID_SPEED, ID_BATT, ID_GEAR,
        ID_CLIMATE, ID_COOLANT, ID_LIGHTS, ID_BODY, ID_PARK: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function void decode_frame(logic [ID_W-1:0] id, logic [LEN_W-1:0] len,
                               logic [PL_W-1:0] data);
      logic [7:0]        b [8];
      int unsigned       n;
      logic [CODE_W-1:0] code;
      logic [7:0]        z;
      foreach (b[k]) b[k] = data[8*k +: 8];
      n = (len > 8) ? 8 : len;
      case (id)
        ID_SPEED: if (n >= 4) begin
          speed = {b[0], b[1]};
          rpm   = 14'({b[2], b[3]} >> 2);
        end
        ID_COOLANT: if (n >= 1) begin
          coolant = (b[0] >= COOLANT_TOP) ? COOLANT_MAX : b[0] - COOLANT_OFS;
        end
        ID_BATT: if (n >= 2) begin
          volts = 16'(32'({b[0], b[1]}) * 100);
        end
        ID_ODO: if (n >= 4) begin
          odometer = {b[1], b[2], b[3]};
        end
        ID_BODY: if (n >= 1) begin
          body[6:0] = b[0][6:0];
        end
        ID_LIGHTS: if (n >= 1) begin
          body[7] = b[0][0];
        end
        ID_GEAR: if (n >= 1) begin
          gear = (b[0] >= 1 && b[0] <= 3) ? b[0][1:0] : 2'd0;
        end
        ID_CLIMATE: if (n >= 4) begin
          climate[2:0] = b[0][2:0];
          fan          = b[1][3:1];
          setpoint[0]  = b[2];
          setpoint[1]  = b[3];
          if (n >= 5) climate[5:3] = b[4][2:0];
        end
        ID_STEER: if (n >= 2) begin
          steer = {b[0], b[1]};
        end
        ID_PARK: if (n >= 1) begin
          park_on = b[0][0];
          // the last zone would need a ninth byte, so it always reads clear
          for (int i = 0; i < ZONES; i++) begin
            z = (i < 7) ? b[i+1] : 8'd0;
            if (i + 1 >= n || i == 7 || z == 0) park_dist[i] = DIST_W'(99);
            else if (z >= 6) park_dist[i] = '0;
            else park_dist[i] = DIST_W'((6 - z) * 14);
          end
        end
        ID_BUTTON: if (n >= 2) begin
          code = '0;
          for (int k = 0; k < 8; k++) begin
            if (b[0] == 8'(1 << k)) code = CODE_W'(k + 1);
          end
          if (code != 0) begin
            // drop the oldest event when full
            if (events.size() >= QUEUE_DEPTH) void'(events.pop_front());
            events.push_back({b[1][0], code});
          end
        end
        default: ;
      endcase
    endfunction

    function logic [VAL_W-1:0] signal_value(logic [IDX_W-1:0] idx);
      logic [VAL_W-1:0] v;
      v = '0;
      case (idx)
        SIG_SPEED:      v = VAL_W'(speed);
        SIG_RPM:        v = VAL_W'(rpm);
        SIG_COOLANT:    v = {{(VAL_W-8){coolant[7]}}, coolant};
        SIG_VOLTAGE:    v = VAL_W'(volts);
        SIG_ODOMETER:   v = VAL_W'(odometer);
        SIG_GEAR:       v = VAL_W'(gear);
        SIG_PARK_BRAKE: v = VAL_W'(body[6]);
        SIG_DOOR_FL, SIG_DOOR_FR, SIG_DOOR_RL, SIG_DOOR_RR, SIG_TAILGATE, SIG_BONNET:
          v = VAL_W'(body[int'(idx - SIG_DOOR_FL)]);
        SIG_NEAR_LIGHT: v = VAL_W'(body[7]);
        SIG_AC:         v = VAL_W'(climate[0]);
        SIG_FAN:        v = VAL_W'(fan);
        SIG_SET_DRV:    v = VAL_W'(setpoint[0]);
        SIG_SET_PAS:    v = VAL_W'(setpoint[1]);
        SIG_RECIRC:     v = VAL_W'(climate[1]);
        SIG_VENT_WS, SIG_VENT_MID, SIG_VENT_FLOOR:
          v = VAL_W'(climate[int'(idx - SIG_VENT_WS) + 3]);
        SIG_DUAL_ZONE:  v = VAL_W'(climate[2]);
        SIG_STEERING:   v = {{(VAL_W-16){steer[15]}}, steer};
        SIG_PARK_ON:    v = VAL_W'(park_on);
        default: begin
          if (idx >= SIG_PARK_D0 && idx <= SIG_PARK_D7)
            v = VAL_W'(park_dist[int'(idx - SIG_PARK_D0)]);
        end
      endcase
      return v;
    endfunction

    function void note_request(request_t r);
      reply_t     due;
      logic [4:0] e;
      due = '0;
      case (r.kind)
        REQ_FRAME: decode_frame(r.id, r.len, r.data);
        REQ_READ: begin
          due.value = signal_value(r.idx);
          replies_due.push_back(due);
        end
        REQ_DEQUEUE: begin
          if (events.size() != 0) begin
            e           = events.pop_front();
            due.popped  = 1'b1;
            due.code    = e[3:0];
            due.pressed = e[4];
          end
          replies_due.push_back(due);
        end
        default: ;
      endcase
    endfunction

    function void check_reply(logic [VAL_W-1:0] value, logic popped,
                              logic [CODE_W-1:0] code, logic pressed);
      reply_t want;
      if (replies_due.size() == 0) begin
        $error("result beat with nothing outstanding: read_value %0d", $signed(value));
        mismatches++;
        return;
      end
      want = replies_due.pop_front();
      if (value !== want.value) begin
        $error("read_value: expected %0d, got %0d", $signed(want.value), $signed(value));
        mismatches++;
      end
      if (popped !== want.popped) begin
        $error("event_valid: expected %0d, got %0d", want.popped, popped);
        mismatches++;
      end
      if (code !== want.code) begin
        $error("button_code: expected %0d, got %0d", want.code, code);
        mismatches++;
      end
      if (pressed !== want.pressed) begin
        $error("button_pressed: expected %0d, got %0d", want.pressed, pressed);
        mismatches++;
      end
    endfunction

    function void close_out();
      if (replies_due.size() != 0) begin
        $error("%0d result beats never arrived", replies_due.size());
        mismatches += replies_due.size();
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  csfd_in_if  req_bus ();
  csfd_out_if rsp_bus ();

  can_signal_frame_decoder_top #(
    .EVENT_DEPTH (QUEUE_DEPTH)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (req_bus),
    .out_bus (rsp_bus)
  );

  decoder_mirror mirror;
  int unsigned   useful_sent;
  int unsigned   burst_left;
  bit            steady_send;
  int unsigned   hold_off_asks;

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
      mirror.check_reply(rsp_bus.read_value, rsp_bus.event_valid,
                         rsp_bus.button_code, rsp_bus.button_pressed);
  end

  // Receiver: random stall patterns, with long hold-offs on request
  initial begin : rx_stall
    int unsigned hold_off_served;
    int unsigned phase_left;
    int unsigned tick;
    rx_mode_t    mode;
    logic [7:0]  mask;
    rsp_bus.ready   = 1'b0;
    hold_off_served = 0;
    phase_left      = 0;
    tick            = 0;
    mode            = RX_EAGER;
    mask            = 8'hFF;
    forever begin
      @(negedge clk);
      if (hold_off_asks != hold_off_served) begin
        hold_off_served++;
        rsp_bus.ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        if (phase_left == 0) begin
          mode       = rx_mode_t'($urandom_range(0, 3));
          phase_left = $urandom_range(16, 96);
          mask       = 8'($urandom) | 8'h01;
        end
        phase_left--;
        tick++;
        case (mode)
          RX_EAGER:  rsp_bus.ready = 1'b1;
          RX_MOSTLY: rsp_bus.ready = ($urandom_range(0, 3) != 0);
          RX_SPARSE: rsp_bus.ready = ($urandom_range(0, 3) == 0);
          default:   rsp_bus.ready = mask[tick % 8];
        endcase
      end
    end
  end

  task automatic idle_sender(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      req_bus.valid   = 1'b0;
      req_bus.can_id  = ID_W'($urandom);
      req_bus.payload = {$urandom, $urandom};
    end
  endtask

  task automatic drive_item(input request_t r);
    if (!steady_send && burst_left == 0) begin
      idle_sender(($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4));
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
    end
    if (burst_left != 0) burst_left--;
    @(negedge clk);
    req_bus.valid        = 1'b1;
    req_bus.req_type     = r.kind;
    req_bus.can_id       = r.id;
    req_bus.frame_length = r.len;
    req_bus.payload      = r.data;
    req_bus.signal_index = r.idx;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    mirror.note_request(r);
    if (r.kind == REQ_READ || r.kind == REQ_DEQUEUE ||
        (r.kind == REQ_FRAME && mirror.recognises(r.id)))
      useful_sent++;
  endtask

  // Unused fields carry random noise so every input bit moves
  function automatic request_t noisy_request(input req_t kind);
    request_t r;
    r.kind = kind;
    r.id   = ID_W'($urandom);
    r.len  = LEN_W'($urandom);
    r.data = {$urandom, $urandom};
    r.idx  = IDX_W'($urandom);
    return r;
  endfunction

  task automatic send_frame(input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len,
                            input logic [PL_W-1:0] data);
    request_t r;
    r      = noisy_request(REQ_FRAME);
    r.id   = id;
    r.len  = len;
    r.data = data;
    drive_item(r);
  endtask

  task automatic send_read(input logic [IDX_W-1:0] idx);
    request_t r;
    r     = noisy_request(REQ_READ);
    r.idx = idx;
    drive_item(r);
  endtask

  task automatic send_dequeue();
    drive_item(noisy_request(REQ_DEQUEUE));
  endtask

  task automatic wait_for_replies(input int unsigned limit);
    int unsigned waited;
    waited = 0;
    while (mirror.replies_due.size() != 0 && waited < limit) begin
      @(negedge clk);
      waited++;
    end
  endtask

  task automatic pause_until_drained();
    idle_sender(1);
    wait_for_replies(DRAIN_LIMIT);
  endtask

  // Stall the receiver for a long stretch while reads keep coming back to back
  task automatic pressure_hold();
    hold_off_asks++;
    steady_send = 1'b1;
    repeat (30) send_read(IDX_W'($urandom_range(0, 32)));
    steady_send = 1'b0;
  endtask

  function automatic logic [LEN_W-1:0] pick_length();
    return ($urandom_range(0, 4) == 0) ? LEN_W'($urandom_range(0, 15))
                                       : LEN_W'($urandom_range(4, 8));
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    return ($urandom_range(0, 7) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(0, 32));
  endfunction

  function automatic logic [PL_W-1:0] shape_payload(input logic [ID_W-1:0] id);
    logic [PL_W-1:0] data;
    data = {$urandom, $urandom};
    case (id)
      ID_COOLANT: if ($urandom_range(0, 1) == 0) begin
        // hug the offset and the clamp threshold
        data[7:0] = $urandom_range(0, 1) ? 8'($urandom_range(36, 44))
                                         : 8'($urandom_range(163, 171));
      end
      ID_GEAR: if ($urandom_range(0, 3) != 0) data[7:0] = 8'($urandom_range(0, 4));
      ID_PARK: begin
        for (int k = 1; k < 8; k++) begin
          if ($urandom_range(0, 3) != 0) data[8*k +: 8] = 8'($urandom_range(0, 7));
        end
      end
      ID_BUTTON: if ($urandom_range(0, 7) != 0) data[7:0] = 8'(1 << $urandom_range(0, 7));
      default: ;
    endcase
    return data;
  endfunction

  task automatic run_episode();
    request_t        r;
    int unsigned     pick;
    logic [ID_W-1:0] id;
    pick = $urandom_range(0, 19);
    if (pick < 9) begin
      id = KNOWN_IDS[$urandom_range(0, 10)];
      send_frame(id, pick_length(), shape_payload(id));
      repeat ($urandom_range(0, 3)) send_read(pick_index());
    end else if (pick < 12) begin
      repeat ($urandom_range(1, 12)) send_frame(ID_BUTTON, pick_length(), shape_payload(ID_BUTTON));
      repeat ($urandom_range(0, 12)) send_dequeue();
    end else if (pick < 15) begin
      repeat ($urandom_range(1, 6)) send_read(pick_index());
    end else if (pick < 17) begin
      repeat ($urandom_range(1, 3)) send_dequeue();
    end else begin
      r = noisy_request(req_t'($urandom_range(0, 3)));
      if (r.kind == REQ_FRAME && $urandom_range(0, 1) == 0)
        r.id = KNOWN_IDS[$urandom_range(0, 10)] ^ (ID_W'(1) << $urandom_range(0, ID_W - 1));
      drive_item(r);
    end
  endtask

  initial begin
    mirror               = new();
    useful_sent          = 0;
    burst_left           = 0;
    steady_send          = 1'b0;
    hold_off_asks        = 0;
    rst_n                = 1'b0;
    req_bus.valid        = 1'b0;
    req_bus.req_type     = REQ_FRAME;
    req_bus.can_id       = '0;
    req_bus.frame_length = '0;
    req_bus.payload      = '0;
    req_bus.signal_index = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_read(SIG_SPEED);
    send_frame(ID_SPEED, 4'd3, '1);       // one byte short: ignored
    send_frame(ID_SPEED, 4'd4, '1);
    send_read(SIG_RPM);
    send_frame(ID_COOLANT, 4'd1, 64'h00); // below the offset: negative
    send_read(SIG_COOLANT);
    send_frame(ID_COOLANT, 4'd15, 64'hA7);
    send_frame(ID_BATT, 4'd2, 64'hFFFF);
    send_frame(ID_ODO, 4'd8, '1);
    send_frame(ID_BODY, 4'd1, 64'h7F);
    send_frame(ID_LIGHTS, 4'd1, 64'h01);
    send_frame(ID_GEAR, 4'd1, 64'h04);
    send_frame(ID_CLIMATE, 4'd5, 64'h07_80FF_0F07);
    send_frame(ID_STEER, 4'd2, 64'h0080);
    send_read(SIG_STEERING);
    send_frame(ID_PARK, 4'd8, 64'hFF07_0605_0201_0001);
    send_read(SIG_PARK_D7);
    send_frame(ID_BUTTON, 4'd2, 64'h0180);
    send_frame(ID_BUTTON, 4'd2, 64'h0103); // not one-hot: no event
    send_frame(ID_BUTTON, 4'd1, 64'h01);   // too short
    send_dequeue();
    send_dequeue();                         // queue now empty
    send_read(6'd63);
    drive_item(noisy_request(REQ_UNUSED));
    send_frame(ID_W'(29'h1FFF_FFFF), 4'd8, '1);

    pressure_hold();
    pause_until_drained();

    while (useful_sent < ITEM_TARGET) begin
      run_episode();
      if ($urandom_range(0, 99) == 0) pressure_hold();
      else if ($urandom_range(0, 79) == 0) pause_until_drained();
    end

    idle_sender(1);
    wait_for_replies(DRAIN_LIMIT);
    repeat (8) @(posedge clk);
    mirror.close_out();
    if (mirror.mismatches == 0) begin
      $display("[can_signal_frame_decoder_top] OK");
    end else begin
      $display("[can_signal_frame_decoder_top] ERROR");
    end
    $finish;
  end

  initial begin : run_limit
    #5_000_000;
    $display("[can_signal_frame_decoder_top] ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/csfd_pkg.sv
rtl/csfd_if.sv
rtl/csfd_sig_bank.sv
rtl/csfd_evq.sv
rtl/can_signal_frame_decoder_top.sv
rtl/csfd_chk.sv
bench/tb_can_signal_frame_decoder_top.sv
